[design/olid_pkg.sv]
// package: shared types, codes and constants for the ordered list block
`default_nettype none

package olid_pkg;

	// default list capacity
	localparam int unsigned CAPACITY_DEF = 16;

	// fixed field widths
	localparam int unsigned POS_W = 5;
	localparam int unsigned VAL_W = 32;
	localparam int unsigned STS_W = 2;
	localparam int unsigned CNT_OUT_W = 5;

	// operation codes
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_DELETE = 1'b1;

	// result status codes
	localparam logic [STS_W-1:0] ST_DONE   = 2'd0;
	localparam logic [STS_W-1:0] ST_FULL   = 2'd1;
	localparam logic [STS_W-1:0] ST_BADPOS = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} olid_cmd_t;

endpackage

`default_nettype wire

[design/olid_ctrl.sv]
// controller: two-state sequencer for request capture and execution
`default_nettype none

module olid_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	output logic                  done,
	output olid_pkg::olid_cmd_t   cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	// next state
	always_comb begin
		case (state_q)
			S_IDLE: state_d = start ? S_EXEC : S_IDLE;
			S_EXEC: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EXEC);
		end
	end

	// commands to the datapath
	assign busy     = (state_q == S_EXEC);
	assign cmd.load = start && (state_q == S_IDLE);
	assign cmd.exec = (state_q == S_EXEC);
	assign done     = done_q;

endmodule

`default_nettype wire

[design/olid_dp.sv]
// datapath: list cells, request registers, range checks and result registers
`default_nettype none

module olid_dp #(
	parameter int unsigned CAPACITY = olid_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire olid_pkg::olid_cmd_t                 cmd,
	input  wire logic                                func,
	input  wire logic [olid_pkg::POS_W-1:0]          position,
	input  wire logic signed [olid_pkg::VAL_W-1:0]   new_value,
	output logic [olid_pkg::STS_W-1:0]               status,
	output logic signed [olid_pkg::VAL_W-1:0]        removed_value,
	output logic [olid_pkg::CNT_OUT_W-1:0]           entry_count
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > olid_pkg::POS_W) ? CW : olid_pkg::POS_W;
	localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                             func_q;
	logic [olid_pkg::POS_W-1:0]       pos_q;
	logic [olid_pkg::VAL_W-1:0]       val_q;
	logic [CW-1:0]                    count_q;
	logic [olid_pkg::VAL_W-1:0]       cell_q [CAPACITY];
	logic [olid_pkg::STS_W-1:0]       status_q;
	logic [olid_pkg::VAL_W-1:0]       removed_q;

	logic [PW-1:0]                    idx;
	logic [PW-1:0]                    cnt_x;
	logic                             full;
	logic                             ins_ok;
	logic                             del_ok;
	logic [olid_pkg::STS_W-1:0]       status_d;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			pos_q  <= position;
			val_q  <= new_value;
		end
	end

	// range checks on the held request
	always_comb begin
		idx    = PW'(pos_q) - PW'(1);
		cnt_x  = PW'(count_q);
		full   = (count_q == CW'(CAPACITY));
		ins_ok = !full && (pos_q != '0) && (idx <= cnt_x);
		del_ok = (pos_q != '0) && (idx < cnt_x);
		if (func_q == olid_pkg::FUNC_INSERT) begin
			if (full)
				status_d = olid_pkg::ST_FULL;
			else if (!ins_ok)
				status_d = olid_pkg::ST_BADPOS;
			else
				status_d = olid_pkg::ST_DONE;
		end else begin
			status_d = del_ok ? olid_pkg::ST_DONE : olid_pkg::ST_BADPOS;
		end
	end

	// list cells: cells from the position on shift in parallel
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (func_q == olid_pkg::FUNC_INSERT && ins_ok) begin
					if (PW'(k) == idx)
						cell_q[k] <= val_q;
					else if (k > 0 && PW'(k) > idx)
						cell_q[k] <= cell_q[(k > 0) ? k - 1 : 0];
				end else if (func_q == olid_pkg::FUNC_DELETE && del_ok) begin
					if (k < CAPACITY - 1 && PW'(k) >= idx)
						cell_q[k] <= cell_q[(k < CAPACITY - 1) ? k + 1 : k];
				end
			end
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (func_q == olid_pkg::FUNC_INSERT && ins_ok)
				count_q <= count_q + CW'(1);
			else if (func_q == olid_pkg::FUNC_DELETE && del_ok)
				count_q <= count_q - CW'(1);
		end
	end

	// result word registers
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			if (func_q == olid_pkg::FUNC_DELETE && del_ok)
				removed_q <= cell_q[idx[IW-1:0]];
			else
				removed_q <= '0;
		end
	end

	assign status        = status_q;
	assign removed_value = removed_q;
	assign entry_count   = olid_pkg::CNT_OUT_W'(count_q);

endmodule

`default_nettype wire

[design/ordered_list_insert_delete.sv]
// top level: ordered list with insert and delete at a position
//
//   channel   direction  handshake         word
//   request   in         start / busy      func, position, new_value
//   result    out        done (strobe)     status, removed_value, entry_count
//
// a request is captured, then in the execute state the range is checked,
// cells from the position on shift in parallel and the result is registered.
// done is high for one cycle, the cycle after execution; a new request may
// be taken in that same cycle. busy is high during the execute cycle.
// arst_n clears the entry count and the sequencer; cell contents are kept.
// the receiver cannot stall the result.
`default_nettype none

module ordered_list_insert_delete #(
	parameter int unsigned CAPACITY = olid_pkg::CAPACITY_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                func,
	input  wire logic [olid_pkg::POS_W-1:0]          position,
	input  wire logic signed [olid_pkg::VAL_W-1:0]   new_value,
	output logic                                     done,
	output logic [olid_pkg::STS_W-1:0]               status,
	output logic signed [olid_pkg::VAL_W-1:0]        removed_value,
	output logic [olid_pkg::CNT_OUT_W-1:0]           entry_count
);

	olid_pkg::olid_cmd_t cmd;

	// sequencer
	olid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// list storage and checks
	olid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (func),
		.position      (position),
		.new_value     (new_value),
		.status        (status),
		.removed_value (removed_value),
		.entry_count   (entry_count)
	);

endmodule

`default_nettype wire

[design/olid_chk.sv]
// checker: port-level properties of the ordered list block, bound to the top level
`default_nettype none

module olid_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               start,
	input wire logic                               busy,
	input wire logic                               func,
	input wire logic                               done,
	input wire logic [olid_pkg::STS_W-1:0]         status,
	input wire logic signed [olid_pkg::VAL_W-1:0]  removed_value
);

	// an accepted request goes busy for exactly one cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without busy");

	// execution always ends in a result word
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execution did not produce a result");

	// failed requests never return a value
	a_zero_removed: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != olid_pkg::ST_DONE) |-> removed_value == '0)
		else $error("failed request returned a value");

	// list full is only reported for an insert
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == olid_pkg::ST_FULL) |-> $past(func, 2) == olid_pkg::FUNC_INSERT)
		else $error("list full reported for a delete");

endmodule

bind ordered_list_insert_delete olid_chk u_olid_chk (.*);

`default_nettype wire

[dv/tb_ordered_list_insert_delete.sv]
// testbench: ordered list insert/delete checked word by word against a shadow list
module tb_ordered_list_insert_delete;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP        = olid_pkg::CAPACITY_DEF;
	localparam int unsigned NUM_RANDOM = 1450;
	localparam int unsigned MAX_CYCLES = 300000;

	// one result word as the block should present it
	typedef struct {
		logic [olid_pkg::STS_W-1:0]        status;
		logic signed [olid_pkg::VAL_W-1:0] removed;
		logic [olid_pkg::CNT_OUT_W-1:0]    count;
	} list_outcome_t;

	// shadow copy of the list plus the queue of outcomes still owed
	class list_checker;
		logic signed [olid_pkg::VAL_W-1:0] cells [CAP];
		int unsigned held;
		list_outcome_t pending_outcomes [$];
		int unsigned errors;
		int unsigned n_req, n_ins, n_del, n_full, n_bad, n_full_hits;

		function new();
			foreach (cells[i]) cells[i] = '0;
			held = 0;
		endfunction

		function int unsigned pending();
			return pending_outcomes.size();
		endfunction

		// apply one accepted request word to the shadow list
		function void note_request(logic f, logic [olid_pkg::POS_W-1:0] pos,
				logic signed [olid_pkg::VAL_W-1:0] val);
			list_outcome_t r;
			int p;
			p = pos;
			r.status = olid_pkg::ST_DONE;
			r.removed = '0;
			n_req++;
			if (f == olid_pkg::FUNC_INSERT) begin
				// fullness wins over a bad position
				if (held >= CAP) begin
					r.status = olid_pkg::ST_FULL;
					n_full++;
				end else if (p < 1 || p > held + 1) begin
					r.status = olid_pkg::ST_BADPOS;
					n_bad++;
				end else begin
					for (int k = held; k >= p; k--) cells[k] = cells[k-1];
					cells[p-1] = val;
					held++;
					n_ins++;
					if (held == CAP) n_full_hits++;
				end
			end else begin
				if (p < 1 || p > held) begin
					r.status = olid_pkg::ST_BADPOS;
					n_bad++;
				end else begin
					r.removed = cells[p-1];
					for (int k = p - 1; k + 1 < held; k++) cells[k] = cells[k+1];
					held--;
					n_del++;
				end
			end
			r.count = held[olid_pkg::CNT_OUT_W-1:0];
			pending_outcomes.push_back(r);
		endfunction

		// compare a result word with the oldest owed outcome
		function void check_result(logic [olid_pkg::STS_W-1:0] sts,
				logic signed [olid_pkg::VAL_W-1:0] rem,
				logic [olid_pkg::CNT_OUT_W-1:0] cnt);
			list_outcome_t r;
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result word: expected none, actual status %0d removed %0d count %0d",
					$time, sts, rem, cnt);
				return;
			end
			r = pending_outcomes.pop_front();
			if (sts !== r.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, sts);
			end
			if (rem !== r.removed) begin
				errors++;
				$display("%0t: removed_value mismatch: expected %0d actual %0d",
					$time, r.removed, rem);
			end
			if (cnt !== r.count) begin
				errors++;
				$display("%0t: entry_count mismatch: expected %0d actual %0d",
					$time, r.count, cnt);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic func = olid_pkg::FUNC_INSERT;
	logic [olid_pkg::POS_W-1:0] position = '0;
	logic signed [olid_pkg::VAL_W-1:0] new_value = '0;
	logic busy;
	logic done;
	logic [olid_pkg::STS_W-1:0] status;
	logic signed [olid_pkg::VAL_W-1:0] removed_value;
	logic [olid_pkg::CNT_OUT_W-1:0] entry_count;

	list_checker chk = new();
	int unsigned burst_left = 0;
	int unsigned cycles = 0;

	ordered_list_insert_delete u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.position     (position),
		.new_value    (new_value),
		.done         (done),
		.status       (status),
		.removed_value(removed_value),
		.entry_count  (entry_count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			chk.check_result(status, removed_value, entry_count);
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	// pick a data value, extremes now and then
	function automatic logic signed [olid_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// present one request word after a random gap and wait until it is taken
	task automatic send_word(input logic f, input logic [olid_pkg::POS_W-1:0] pos,
			input logic signed [olid_pkg::VAL_W-1:0] val);
		int unsigned gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 16);
			if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
		end
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		position <= pos;
		new_value <= val;
		do @(posedge clk); while (busy);
		chk.note_request(f, pos, val);
	endtask

	// hold off until every owed result has come back
	task automatic drain_results();
		start <= 1'b0;
		while (chk.pending() > 0) @(posedge clk);
	endtask

	initial begin
		logic f;
		logic [olid_pkg::POS_W-1:0] pos;
		int unsigned c;
		bit filling;
		int unsigned mode_left;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty list corner cases
		send_word(olid_pkg::FUNC_DELETE, 5'd1, 32'sd7);
		send_word(olid_pkg::FUNC_DELETE, 5'd0, 32'sd0);
		send_word(olid_pkg::FUNC_INSERT, 5'd0, 32'sd1);
		send_word(olid_pkg::FUNC_INSERT, 5'd2, 32'sd1);

		// directed: fill to capacity at front, end and middle
		for (int i = 0; i < CAP; i++) begin
			c = chk.held;
			case (i % 4)
				0: pos = 5'd1;
				1: pos = olid_pkg::POS_W'(c + 1);
				2: pos = olid_pkg::POS_W'(c / 2 + 1);
				default: pos = olid_pkg::POS_W'(c + 1);
			endcase
			case (i % 5)
				0: send_word(olid_pkg::FUNC_INSERT, pos, 32'sh8000_0000);
				1: send_word(olid_pkg::FUNC_INSERT, pos, 32'sh7fff_ffff);
				2: send_word(olid_pkg::FUNC_INSERT, pos, -32'sd1);
				default: send_word(olid_pkg::FUNC_INSERT, pos, $urandom);
			endcase
		end

		// directed: full list, bad positions, deletes at both ends
		send_word(olid_pkg::FUNC_INSERT, 5'd17, 32'sd5);
		send_word(olid_pkg::FUNC_INSERT, 5'd0, 32'sd5);
		send_word(olid_pkg::FUNC_DELETE, 5'd17, 32'sd0);
		send_word(olid_pkg::FUNC_DELETE, 5'd16, 32'sd0);
		send_word(olid_pkg::FUNC_DELETE, 5'd1, 32'sd0);
		send_word(olid_pkg::FUNC_DELETE, 5'd0, 32'sd0);
		send_word(olid_pkg::FUNC_INSERT, 5'd16, 32'sd9);
		drain_results();

		// random: drift between filling and draining, with some noise
		filling = 1'b0;
		mode_left = $urandom_range(20, 80);
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if (mode_left == 0) begin
				filling = !filling;
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			c = chk.held;
			if ($urandom_range(0, 99) < 12) begin
				f = 1'($urandom_range(0, 1));
				pos = olid_pkg::POS_W'($urandom_range(0, 17));
			end else begin
				if (c == 0)
					f = olid_pkg::FUNC_INSERT;
				else if (c == CAP)
					f = olid_pkg::FUNC_DELETE;
				else if (filling)
					f = ($urandom_range(0, 99) < 75) ? olid_pkg::FUNC_INSERT
						: olid_pkg::FUNC_DELETE;
				else
					f = ($urandom_range(0, 99) < 25) ? olid_pkg::FUNC_INSERT
						: olid_pkg::FUNC_DELETE;
				if (f == olid_pkg::FUNC_INSERT)
					pos = olid_pkg::POS_W'($urandom_range(1, c + 1));
				else
					pos = olid_pkg::POS_W'($urandom_range(1, c));
			end
			send_word(f, pos, pick_value());
			if (n % 400 == 200) drain_results();
		end

		// wrap up
		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d requests: %0d inserts, %0d deletes, %0d full rejects, %0d bad positions",
			chk.n_req, chk.n_ins, chk.n_del, chk.n_full, chk.n_bad);
		$display("list reached capacity %0d times, %0d mismatches seen",
			chk.n_full_hits, chk.errors);
		if (chk.errors == 0 && chk.pending() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
